[rtl/cddf_pkg.sv]
package cddf_pkg;

    localparam int SET_DEPTH = 256;
    localparam int CP_W      = 21;
    localparam int SLOT_W    = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);

    localparam int S_DATA_W  = ((CP_W + 7) / 8) * 8;
    localparam int M_FIELD_W = CP_W + SLOT_W + CNT_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_USER_W  = 2;

    localparam int M_SLOT_LSB  = CP_W;
    localparam int M_COUNT_LSB = CP_W + SLOT_W;
    localparam int M_USER_KEPT = 0;
    localparam int M_USER_OVF  = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } cddf_state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } cddf_cmd_t;

    typedef struct packed {
        logic hit;
        logic miss_done;
        logic out_free;
    } cddf_stat_t;

endpackage

[rtl/cddf_ctrl.sv]
module cddf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cddf_pkg::cddf_stat_t stat,
    output cddf_pkg::cddf_cmd_t  cmd
);
    import cddf_pkg::*;

    cddf_state_t state_reg;
    cddf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.hit || stat.miss_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.search = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/cddf_dp.sv]
module cddf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cddf_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    input  cddf_pkg::cddf_cmd_t            cmd,
    output cddf_pkg::cddf_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cddf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [cddf_pkg::M_USER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import cddf_pkg::*;

    logic [CP_W-1:0] mem [SET_DEPTH];

    logic [CP_W-1:0]   cp_reg,        cp_next;
    logic              last_reg,      last_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic              rd_vld_reg,    rd_vld_next;
    logic [SLOT_W-1:0] rd_idx_reg,    rd_idx_next;
    logic [CP_W-1:0]   rd_data_reg;
    logic              hit_reg,       hit_next;
    logic [SLOT_W-1:0] hit_slot_reg,  hit_slot_next;
    logic              m_valid_reg,   m_valid_next;
    logic [CP_W-1:0]   m_cp_reg,      m_cp_next;
    logic              m_kept_reg,    m_kept_next;
    logic [SLOT_W-1:0] m_slot_reg,    m_slot_next;
    logic [CNT_W-1:0]  m_count_reg,   m_count_next;
    logic              m_ovf_reg,     m_ovf_next;
    logic              m_last_reg,    m_last_next;

    logic hit;
    logic issue;
    logic full;
    logic mem_we;

    assign hit    = rd_vld_reg && (rd_data_reg == cp_reg);
    assign issue  = cmd.search && !hit && (idx_reg < count_reg);
    assign full   = (count_reg == CNT_W'(SET_DEPTH));
    assign mem_we = cmd.commit && !hit_reg && !full;

    assign stat.hit       = cmd.search && hit;
    assign stat.miss_done = !rd_vld_reg && (idx_reg >= count_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        cp_next       = cp_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_cp_next     = m_cp_reg;
        m_kept_next   = m_kept_reg;
        m_slot_next   = m_slot_reg;
        m_count_next  = m_count_reg;
        m_ovf_next    = m_ovf_reg;
        m_last_next   = m_last_reg;

        if (cmd.load)
        begin
            cp_next   = s_tdata[CP_W-1:0];
            last_next = s_tlast;
            idx_next  = '0;
            hit_next  = 1'b0;
            if (s_tuser)
            begin
                count_next = '0;
            end
        end

        if (cmd.search)
        begin
            if (hit)
            begin
                hit_next      = 1'b1;
                hit_slot_next = rd_idx_reg;
            end
            if (issue)
            begin
                rd_vld_next = 1'b1;
                rd_idx_next = idx_reg[SLOT_W-1:0];
                idx_next    = idx_reg + CNT_W'(1);
            end
        end

        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
            m_cp_next    = cp_reg;
            m_last_next  = last_reg;
            m_kept_next  = mem_we;
            m_ovf_next   = !hit_reg && full;
            if (hit_reg)
            begin
                m_slot_next = hit_slot_reg;
            end
            else if (full)
            begin
                m_slot_next = '0;
            end
            else
            begin
                m_slot_next = count_reg[SLOT_W-1:0];
            end
            if (mem_we)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            m_count_next = mem_we ? (count_reg + CNT_W'(1)) : count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[SLOT_W-1:0]] <= cp_reg;
        end
        rd_data_reg <= mem[idx_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg       <= cp_next;
        last_reg     <= last_next;
        rd_idx_reg   <= rd_idx_next;
        hit_slot_reg <= hit_slot_next;
        m_cp_reg     <= m_cp_next;
        m_kept_reg   <= m_kept_next;
        m_slot_reg   <= m_slot_next;
        m_count_reg  <= m_count_next;
        m_ovf_reg    <= m_ovf_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_count_reg, m_slot_reg, m_cp_reg});
    assign m_tuser  = {m_ovf_reg, m_kept_reg};
    assign m_tlast  = m_last_reg;

endmodule

[rtl/codepoint_dedup_filter_top.sv]
// Order-preserving duplicate filter for a stream of codepoints.
// Input words arrive on the s_ group: s_tdata carries the codepoint, s_tuser
// marks the first word of a list (the stored set is emptied before it is
// handled) and s_tlast marks the last word, which is copied to m_tlast.
// Each input word gives exactly one output word on the m_ group, telling
// whether the codepoint was new and stored (kept), its slot in the set, the
// running unique count and whether it was new but found the set full (overflow).
// The set lives in a memory that is scanned one entry per cycle from slot 0,
// so a word's result is registered sooner the lower the slot that it matches
// in, and only after all stored entries have been read when it matches none.
// One word is worked on at a time, and s_tready is high only while the block
// waits for a word, so the next word can be taken at the earliest in the cycle
// after the previous result is registered.
// The result sits in an output register; when the receiver stalls, the next
// word is still taken and searched, and its result waits until that
// register is free. Reset empties the set and drops any pending result.
module codepoint_dedup_filter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [20:0] codepoint, upper bits zero
    input  logic [cddf_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] first_of_list
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [20:0] codepoint_out, [28:21] slot, [37:29] unique_count, upper bits zero
    output logic [cddf_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] kept, [1] overflow
    output logic [cddf_pkg::M_USER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import cddf_pkg::*;

    cddf_cmd_t  cmd;
    cddf_stat_t stat;

    cddf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cddf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/cddf_checker.sv]
module cddf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cddf_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [cddf_pkg::M_USER_W-1:0]  m_tuser
);
    import cddf_pkg::*;

    logic [SLOT_W-1:0] chk_slot;
    logic [CNT_W-1:0]  chk_count;

    assign chk_slot  = m_tdata[M_SLOT_LSB +: SLOT_W];
    assign chk_count = m_tdata[M_COUNT_LSB +: CNT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Output word changed while stalled.");

    a_kept_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[M_USER_KEPT] && m_tuser[M_USER_OVF]))
        else $error("Word marked both kept and overflow.");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[M_USER_OVF] |-> chk_count == CNT_W'(SET_DEPTH) && chk_slot == '0)
        else $error("Overflow reported while the set was not full.");

    a_kept_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[M_USER_KEPT] |-> (CNT_W'(chk_slot) + CNT_W'(1)) == chk_count)
        else $error("Kept word slot does not match the unique count.");

    a_dup_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[M_USER_KEPT] && !m_tuser[M_USER_OVF]
            |-> CNT_W'(chk_slot) < chk_count)
        else $error("Duplicate word points beyond the stored set.");

endmodule

bind codepoint_dedup_filter_top cddf_checker u_cddf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/codepoint_dedup_filter_top_test.sv]
`timescale 1ns / 100ps

module codepoint_dedup_filter_top_test;

    import cddf_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int TAIL_CYCLES  = SET_DEPTH + 16;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_WORDS = 2000;
    localparam int FILL_EXTRA   = 40;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            first;
        logic            last;
        logic            drain;
        logic            hold;
    } list_word_t;

    typedef struct {
        logic [CP_W-1:0]   cp;
        logic              kept;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              ovf;
        logic              last;
    } dedup_result_t;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    list_word_t      pending_words[$];
    dedup_result_t   expected_results[$];
    logic [CP_W-1:0] seen_set[SET_DEPTH];
    int              seen_count  = 0;
    int              mismatches  = 0;
    int              accepted    = 0;
    int              total_words = 1;
    int              cycles      = 0;
    bit              took        = 0;
    int              hold_req    = 0;
    int              hold_seen   = 0;
    int              hold_left   = 0;

    codepoint_dedup_filter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic dedup_result_t dedup_predict(logic [CP_W-1:0] cp, logic first,
                                                    logic last);
        dedup_result_t r;
        bit            found;
        r.cp   = cp;
        r.kept = 1'b0;
        r.slot = '0;
        r.ovf  = 1'b0;
        r.last = last;
        found  = 0;
        if (first)
            seen_count = 0;
        for (int i = 0; i < seen_count && !found; i++)
        begin
            if (seen_set[i] == cp)
            begin
                found  = 1;
                r.slot = SLOT_W'(i);
            end
        end
        if (!found)
        begin
            if (seen_count < SET_DEPTH)
            begin
                seen_set[seen_count] = cp;
                r.slot = SLOT_W'(seen_count);
                seen_count++;
                r.kept = 1'b1;
            end
            else
                r.ovf = 1'b1;
        end
        r.count = CNT_W'(seen_count);
        return r;
    endfunction

    function automatic int idle_percent(bit receiver);
        int phase;
        phase = (accepted * 3 < total_words) ? 0 : (accepted * 3 < 2 * total_words) ? 1 : 2;
        case (phase)
            0: return receiver ? 67 : 13;
            1: return receiver ? 13 : 67;
            default: return 0;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] random_codepoint();
        case ($urandom_range(0, 5))
            0: return CP_W'(32'h0);
            1: return {CP_W{1'b1}};
            2: return CP_W'(32'h10FFFF);
            3: return CP_W'($urandom_range(32, 127));
            default: return CP_W'($urandom());
        endcase
    endfunction

    task automatic push_word(logic [CP_W-1:0] cp, logic first, logic last,
                             logic drain = 1'b0, logic hold = 1'b0);
        list_word_t w;
        w.cp    = cp;
        w.first = first;
        w.last  = last;
        w.drain = drain;
        w.hold  = hold;
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : monitor
        dedup_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("output word with none pending", m_tdata, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.cp)
                        report_mismatch("codepoint_out", m_tdata[CP_W-1:0], want.cp);
                    if (m_tdata[M_SLOT_LSB +: SLOT_W] !== want.slot)
                        report_mismatch("slot", m_tdata[M_SLOT_LSB +: SLOT_W], want.slot);
                    if (m_tdata[M_COUNT_LSB +: CNT_W] !== want.count)
                        report_mismatch("unique_count", m_tdata[M_COUNT_LSB +: CNT_W],
                                        want.count);
                    if (m_tuser[M_USER_KEPT] !== want.kept)
                        report_mismatch("kept", m_tuser[M_USER_KEPT], want.kept);
                    if (m_tuser[M_USER_OVF] !== want.ovf)
                        report_mismatch("overflow", m_tuser[M_USER_OVF], want.ovf);
                    if (m_tlast !== want.last)
                        report_mismatch("last_out", m_tlast, want.last);
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(dedup_predict(s_tdata[CP_W-1:0], s_tuser, s_tlast));
                accepted++;
                took = 1;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        list_word_t          w;
        logic                v;
        logic [S_DATA_W-1:0] d;
        logic                u;
        logic                l;
        bit                  send;
        if (rst_n)
        begin
            v = s_tvalid;
            d = s_tdata;
            u = s_tuser;
            l = s_tlast;
            if (!s_tvalid || took)
            begin
                took = 0;
                v    = 1'b0;
                if (pending_words.size() != 0)
                begin
                    w    = pending_words[0];
                    send = ($urandom_range(0, 99) >= idle_percent(0));
                    // A draining word waits until every result has been returned.
                    if (w.drain && expected_results.size() != 0)
                        send = 0;
                    if (send)
                    begin
                        void'(pending_words.pop_front());
                        v = 1'b1;
                        d = '0;
                        d[CP_W-1:0] = w.cp;
                        u = w.first;
                        l = w.last;
                        if (w.hold)
                            hold_req <= hold_req + 1;
                    end
                end
            end
            s_tvalid <= v;
            s_tdata  <= d;
            s_tuser  <= u;
            s_tlast  <= l;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= idle_percent(1));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("codepoint_dedup_filter_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CP_W-1:0] alphabet[12];
        logic [CP_W-1:0] fill_cps[SET_DEPTH];
        int              made;
        int              len;
        int              width;
        int              pick;
        int              fills;
        int              holds;
        logic [CP_W-1:0] cp;

        push_word(CP_W'(32'h0), 1'b1, 1'b0);
        push_word({CP_W{1'b1}}, 1'b0, 1'b0);
        push_word(CP_W'(32'h10FFFF), 1'b0, 1'b0);
        push_word(CP_W'(32'h0), 1'b0, 1'b0);
        push_word({CP_W{1'b1}}, 1'b0, 1'b1);
        push_word(CP_W'(32'h10FFFF), 1'b0, 1'b0);
        push_word(CP_W'(32'h0AAAAA), 1'b0, 1'b0);
        push_word(CP_W'(32'h155555), 1'b0, 1'b1);
        push_word(CP_W'(32'h41), 1'b1, 1'b1);
        push_word(CP_W'(32'h41), 1'b1, 1'b0);
        push_word(CP_W'(32'h41), 1'b0, 1'b0);
        push_word(CP_W'(32'h42), 1'b0, 1'b0);
        push_word(CP_W'(32'h41), 1'b0, 1'b1);
        push_word(CP_W'(32'h110000), 1'b1, 1'b0);
        push_word(CP_W'(32'h110000), 1'b0, 1'b1);

        made  = 0;
        fills = 0;
        holds = 0;
        while (made < RANDOM_WORDS)
        begin
            if ((fills == 0 && made >= 400) || (fills == 1 && made >= 1300))
            begin
                // Fill the set completely, then mix repeats with words that overflow.
                for (int i = 0; i < SET_DEPTH; i++)
                begin
                    fill_cps[i] = {CP_W'($urandom_range(0, 8191)) << 8} | CP_W'(i);
                    push_word(fill_cps[i], i == 0, 1'b0, i == 0);
                end
                for (int i = 0; i < FILL_EXTRA; i++)
                begin
                    if ($urandom_range(0, 1))
                        cp = fill_cps[$urandom_range(0, SET_DEPTH - 1)];
                    else
                        cp = random_codepoint();
                    push_word(cp, 1'b0, i == FILL_EXTRA - 1);
                end
                made += SET_DEPTH + FILL_EXTRA;
                fills++;
            end
            else if ((holds == 0 && made >= 150) || (holds == 1 && made >= 1000))
            begin
                push_word(random_codepoint(), 1'b1, 1'b0, 1'b0, 1'b1);
                for (int i = 0; i < 20; i++)
                    push_word(CP_W'($urandom_range(0, 15)), 1'b0, i == 19);
                push_word(random_codepoint(), 1'b1, 1'b1, 1'b1);
                made += 22;
                holds++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    len   = $urandom_range(1, 24);
                    width = $urandom_range(1, 12);
                    for (int i = 0; i < width; i++)
                        alphabet[i] = random_codepoint();
                    for (int i = 0; i < len; i++)
                        push_word(alphabet[$urandom_range(0, width - 1)], i == 0, i == len - 1);
                    made += len;
                end
                else if (pick < 90)
                begin
                    push_word(random_codepoint(), $urandom_range(0, 1), $urandom_range(0, 1));
                    made++;
                end
                else
                begin
                    len = $urandom_range(1, 16);
                    for (int i = 0; i < len; i++)
                        push_word(random_codepoint(), 1'b0,
                                  (i == len - 1) && $urandom_range(0, 1));
                    made += len;
                end
            end
        end
        total_words = pending_words.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("codepoint_dedup_filter_top_test OK");
        else
            $display("codepoint_dedup_filter_top_test NOT OK");
        $finish;
    end

endmodule
